### rtl/debug_tx_ring_buffer_assert.svh
// assertion macros for the debug transmit ring buffer
// used by rtl/debug_tx_ring_buffer.sv, no other dependencies
`ifndef DEBUG_TX_RING_BUFFER_ASSERT_SVH
`define DEBUG_TX_RING_BUFFER_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define DTRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dtrb assertion failed");

// next-cycle implication, disabled while reset is active
`define DTRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dtrb assertion failed");

`endif

### rtl/dtrb_pkg.sv
// types, constants and helper functions for the debug transmit ring buffer
// no dependencies
package dtrb_pkg;

	localparam int DEPTH      = 128;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int BANK_DEPTH = (DEPTH + 1) / 2;
	localparam int BANK_AW    = IDX_W - 1;
	localparam int MARK_LEN   = 8;

	// overflow marker: LF CR "lost" LF CR
	localparam logic [7:0] LOST_MARKER [MARK_LEN] = '{
		8'h0a, 8'h0d, 8'h6c, 8'h6f, 8'h73, 8'h74, 8'h0a, 8'h0d
	};

	typedef enum logic [1:0] {
		OP_RAW   = 2'd0,
		OP_DIGIT = 2'd1,
		OP_HEX   = 2'd2,
		OP_POP   = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       buf_full;
		logic       buf_empty;
	} result_t;

	function automatic logic [7:0] hex_char(input logic [7:0] v);
		if (v <= 8'd9) begin
			return v + 8'h30;
		end
		return v + 8'd55;
	endfunction

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
		if (p == IDX_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

endpackage

### rtl/debug_tx_ring_buffer.sv
// debug transmit ring buffer top level
// depends on rtl/dtrb_pkg.sv and rtl/debug_tx_ring_buffer_assert.svh
//
// usage
//  - a request is taken on a rising edge with start high and busy low; busy is
//    always low, so one request can be issued every cycle
//  - cmd.op selects raw push, hex digit push, hex byte push (two digits, high
//    nibble first) or pop; cmd.data carries the byte or digit value
//  - every request gives exactly one result, in the following cycle: done is high for
//    one cycle with result valid alongside it; the receiver cannot stall it
//  - result.tx_valid marks a popped byte, result.tx_byte is zero without one;
//    buf_full / buf_empty are the flags after the request
//  - throughput 1 request per cycle; a hex byte push and the 8-byte overflow
//    marker write both finish within that single request
//  - storage: slots 0..7 are flops (the marker rewrites them all at once), the
//    rest live in two banks with one write and one read port each, split by address
//    parity, so the two digits of a hex byte never land in the same bank
//  - reset clears pointers and flags (empty set, full clear); store contents are
//    not cleared and need no clearing pass
//  - a push while full drops the byte, writes the marker, sets write to 8 and
//    read to 0, and keeps full set until the next pop
`include "debug_tx_ring_buffer_assert.svh"

module debug_tx_ring_buffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dtrb_pkg::cmd_t    cmd,
	output logic              done,
	output dtrb_pkg::result_t result
);
	import dtrb_pkg::*;

	// pointer and flag state
	logic [IDX_W-1:0] wr_q, rd_q;
	logic             full_q, empty_q;

	// storage: low slots in flops, the rest in even / odd banks
	logic [7:0] lo_slot_q [MARK_LEN];
	logic [7:0] even_mem [BANK_DEPTH];
	logic [7:0] odd_mem  [BANK_DEPTH];

	// result stage
	logic       done_s1;
	logic       tx_valid_s1;
	logic       full_s1, empty_s1;
	logic       rd_lo_s1, rd_odd_s1;
	logic [7:0] lo_rdata_s1, ev_rdata_s1, od_rdata_s1;

	// next-state logic
	logic             accept, is_push, is_hex, is_pop;
	logic [7:0]       c0, c1;
	logic [IDX_W-1:0] wr1, wr2, wr_d, rd_d, rd_inc;
	logic             full1, full2, full_d, empty_d;
	logic             we_a, we_b, mark_we, pop_rd;
	logic             a_lo, b_lo, rd_lo;

	// bank write ports
	logic               ev_we, od_we;
	logic [BANK_AW-1:0] ev_addr, od_addr;
	logic [7:0]         ev_wdata, od_wdata;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_pop  = (cmd.op == OP_POP);
	assign is_hex  = (cmd.op == OP_HEX);
	assign is_push = !is_pop;

	// characters to store for each push flavor
	always_comb begin
		c0 = cmd.data;
		c1 = hex_char({4'h0, cmd.data[3:0]});
		case (cmd.op)
			OP_DIGIT: c0 = hex_char(cmd.data);
			OP_HEX:   c0 = hex_char({4'h0, cmd.data[7:4]});
			default:  c0 = cmd.data;
		endcase
	end

	// first push, then the optional second push of a hex byte
	assign wr1   = full_q ? IDX_W'(MARK_LEN) : idx_inc(wr_q);
	assign full1 = full_q || (wr1 == rd_q);
	assign wr2   = full1 ? IDX_W'(MARK_LEN) : idx_inc(wr1);
	// after a marker rd is 0; second compare uses rd_q, as full1 already covers a marker from push one
	assign full2 = full1 || (wr2 == rd_q);

	assign we_a    = accept && is_push && !full_q;
	assign we_b    = accept && is_hex && !full1;
	assign mark_we = accept && is_push && (full_q || (is_hex && full1));
	assign pop_rd  = accept && is_pop && !empty_q;
	assign rd_inc  = idx_inc(rd_q);

	assign a_lo  = (wr_q < IDX_W'(MARK_LEN));
	assign b_lo  = (wr1 < IDX_W'(MARK_LEN));
	assign rd_lo = (rd_q < IDX_W'(MARK_LEN));

	always_comb begin
		wr_d    = wr_q;
		rd_d    = rd_q;
		full_d  = full_q;
		empty_d = empty_q;
		if (accept) begin
			if (is_pop) begin
				if (!empty_q) begin
					rd_d    = rd_inc;
					full_d  = 1'b0;
					empty_d = (rd_inc == wr_q);
				end
			end else begin
				empty_d = 1'b0;
				if (is_hex) begin
					wr_d   = wr2;
					full_d = full2;
				end else begin
					wr_d   = wr1;
					full_d = full1;
				end
				if (mark_we) begin
					rd_d = '0;
				end
			end
		end
	end

	// bank write muxes; the two pushes of one request always differ in parity
	always_comb begin
		ev_we    = 1'b0;
		ev_addr  = wr_q[IDX_W-1:1];
		ev_wdata = c0;
		od_we    = 1'b0;
		od_addr  = wr_q[IDX_W-1:1];
		od_wdata = c0;
		if (we_a && !a_lo) begin
			if (wr_q[0]) begin
				od_we = 1'b1;
			end else begin
				ev_we = 1'b1;
			end
		end
		if (we_b && !b_lo) begin
			if (wr1[0]) begin
				od_we    = 1'b1;
				od_addr  = wr1[IDX_W-1:1];
				od_wdata = c1;
			end else begin
				ev_we    = 1'b1;
				ev_addr  = wr1[IDX_W-1:1];
				ev_wdata = c1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			full_q  <= 1'b0;
			empty_q <= 1'b1;
			done_s1 <= 1'b0;
		end else begin
			wr_q    <= wr_d;
			rd_q    <= rd_d;
			full_q  <= full_d;
			empty_q <= empty_d;
			done_s1 <= accept;
		end
	end

	// low slots: the marker wins over a digit written earlier in the same request
	always_ff @(posedge clk) begin
		for (int k = 0; k < MARK_LEN; k++) begin
			if (mark_we) begin
				lo_slot_q[k] <= LOST_MARKER[k];
			end else if (we_a && a_lo && (wr_q[2:0] == 3'(k))) begin
				lo_slot_q[k] <= c0;
			end else if (we_b && b_lo && (wr1[2:0] == 3'(k))) begin
				lo_slot_q[k] <= c1;
			end
		end
	end

	// banks: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (ev_we) begin
			even_mem[ev_addr] <= ev_wdata;
		end
		if (pop_rd) begin
			ev_rdata_s1 <= even_mem[rd_q[IDX_W-1:1]];
		end
	end

	always_ff @(posedge clk) begin
		if (od_we) begin
			odd_mem[od_addr] <= od_wdata;
		end
		if (pop_rd) begin
			od_rdata_s1 <= odd_mem[rd_q[IDX_W-1:1]];
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		tx_valid_s1 <= pop_rd;
		full_s1     <= full_d;
		empty_s1    <= empty_d;
		rd_lo_s1    <= rd_lo;
		rd_odd_s1   <= rd_q[0];
		lo_rdata_s1 <= lo_slot_q[rd_q[2:0]];
	end

	// output mux after the result register
	always_comb begin
		result.tx_valid  = tx_valid_s1;
		result.buf_full  = full_s1;
		result.buf_empty = empty_s1;
		if (!tx_valid_s1) begin
			result.tx_byte = '0;
		end else if (rd_lo_s1) begin
			result.tx_byte = lo_rdata_s1;
		end else if (rd_odd_s1) begin
			result.tx_byte = od_rdata_s1;
		end else begin
			result.tx_byte = ev_rdata_s1;
		end
	end

	assign done = done_s1;

	`DTRB_ASSERT_NOW(a_flags_excl, clk, arst_n, 1'b1, !(full_q && empty_q))
	`DTRB_ASSERT_NOW(a_empty_ptrs, clk, arst_n, empty_q, wr_q == rd_q)
	`DTRB_ASSERT_NEXT(a_one_result, clk, arst_n, accept, done)
	`DTRB_ASSERT_NEXT(a_no_result, clk, arst_n, !accept, !done)
	`DTRB_ASSERT_NEXT(a_pop_gives, clk, arst_n, pop_rd, done && result.tx_valid)
	`DTRB_ASSERT_NOW(a_idle_zero, clk, arst_n, !result.tx_valid, result.tx_byte == 8'h00)

endmodule

### tb/tb.sv
// self-checking testbench for the debug transmit ring buffer
// holds a scoreboard class with its own ring model and the top module tb
// depends on rtl/dtrb_pkg.sv and rtl/debug_tx_ring_buffer.sv

module tb;
	import dtrb_pkg::*;

	// bytes written over slots 0..7 when a push finds the ring full
	localparam logic [7:0] OVERFLOW_TEXT [8] = '{
		8'h0a, 8'h0d, "l", "o", "s", "t", 8'h0a, 8'h0d
	};

	class tx_ring_scoreboard;
		logic [7:0]       ring [DEPTH];
		logic [IDX_W-1:0] wr_ptr;
		logic [IDX_W-1:0] rd_ptr;
		bit               is_full;
		bit               is_empty;
		result_t          predicted_results [$];
		int unsigned      errors;
		int unsigned      n_checked;
		int unsigned      n_bytes_out;
		int unsigned      n_empty_pops;
		int unsigned      n_overflow;
		int unsigned      n_full_hits;

		function new();
			wr_ptr = '0;
			rd_ptr = '0;
			is_full = 1'b0;
			is_empty = 1'b1;
		endfunction

		function logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
			if (int'(p) == DEPTH - 1) begin
				return '0;
			end
			return p + 1'b1;
		endfunction

		function logic [7:0] to_hex_char(input logic [7:0] v);
			return (v < 8'd10) ? 8'h30 + v : 8'h37 + v;
		endfunction

		function int free_slots();
			if (is_full) begin
				return 0;
			end
			if (is_empty) begin
				return DEPTH;
			end
			return (int'(rd_ptr) - int'(wr_ptr) + DEPTH) % DEPTH;
		endfunction

		function int pending();
			return predicted_results.size();
		endfunction

		function void put_byte(input logic [7:0] b);
			if (is_full) begin
				for (int k = 0; k < 8; k++) begin
					ring[k] = OVERFLOW_TEXT[k];
				end
				wr_ptr = IDX_W'(8);
				rd_ptr = '0;
				is_empty = 1'b0;
				n_overflow++;
				return;
			end
			ring[wr_ptr] = b;
			wr_ptr = next_slot(wr_ptr);
			is_empty = 1'b0;
			if (wr_ptr == rd_ptr) begin
				is_full = 1'b1;
				n_full_hits++;
			end
		endfunction

		function void note_request(input cmd_t c);
			result_t r;
			r = '0;
			case (c.op)
			OP_RAW: put_byte(c.data);
			OP_DIGIT: put_byte(to_hex_char(c.data));
			OP_HEX: begin
				put_byte(to_hex_char({4'h0, c.data[7:4]}));
				put_byte(to_hex_char({4'h0, c.data[3:0]}));
			end
			default: begin
				if (!is_empty) begin
					r.tx_valid = 1'b1;
					r.tx_byte = ring[rd_ptr];
					rd_ptr = next_slot(rd_ptr);
					is_full = 1'b0;
					if (rd_ptr == wr_ptr) begin
						is_empty = 1'b1;
					end
					n_bytes_out++;
				end else begin
					n_empty_pops++;
				end
			end
			endcase
			r.buf_full = is_full;
			r.buf_empty = is_empty;
			predicted_results.push_back(r);
		endfunction

		task report(input string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_result(input result_t got);
			result_t want;
			if (predicted_results.size() == 0) begin
				report($sformatf("result with nothing outstanding: %h", got));
				return;
			end
			want = predicted_results.pop_front();
			n_checked++;
			if (got.tx_valid !== want.tx_valid) begin
				report($sformatf("result %0d tx_valid %b, want %b",
					n_checked, got.tx_valid, want.tx_valid));
			end
			if (got.tx_byte !== want.tx_byte) begin
				report($sformatf("result %0d tx_byte %h, want %h",
					n_checked, got.tx_byte, want.tx_byte));
			end
			if (got.buf_full !== want.buf_full) begin
				report($sformatf("result %0d buf_full %b, want %b",
					n_checked, got.buf_full, want.buf_full));
			end
			if (got.buf_empty !== want.buf_empty) begin
				report($sformatf("result %0d buf_empty %b, want %b",
					n_checked, got.buf_empty, want.buf_empty));
			end
		endtask
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	cmd_t    cmd = '0;
	logic    done;
	result_t result;

	tx_ring_scoreboard sb = new();

	int unsigned n_requests;
	int unsigned n_random;
	bit          quiet_tail;
	int unsigned idle_pct;

	debug_tx_ring_buffer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// 10 unit period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results cannot be held off, so every strobe is checked at the edge that ends it
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			sb.check_result(result);
		end
	end

	// hand one request to the block; returns in the time step of the accepting edge
	// start stays high so back-to-back requests never drop it in between
	task automatic issue(input op_t op, input logic [7:0] data);
		cmd_t c;
		c.op = op;
		c.data = data;
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy !== 1'b0) begin
			@(posedge clk);
		end
		sb.note_request(c);
		n_requests++;
	endtask

	// sender gap: start low with junk on cmd, the block must ignore it
	task automatic idle_burst(input int unsigned cycles);
		start <= 1'b0;
		cmd <= cmd_t'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// maybe leave a gap after a request, never in the quiet tail
	task automatic maybe_idle();
		if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
			idle_burst($urandom_range(1, 11));
		end
	endtask

	// pause until every outstanding result has been checked
	task automatic drain_results();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
	endtask

	task automatic random_push();
		op_t op;
		op = op_t'($urandom_range(0, 2));
		// with one slot left a hex byte push overflows on its low digit
		if (sb.free_slots() == 1 && $urandom_range(0, 1) == 1) begin
			op = OP_HEX;
		end
		issue(op, 8'($urandom));
		n_random++;
		maybe_idle();
	endtask

	task automatic random_pop();
		issue(OP_POP, 8'($urandom));
		n_random++;
		maybe_idle();
	endtask

	// push mostly until the ring is full, then push into the full ring a few times
	task automatic fill_phase();
		int unsigned guard;
		int unsigned extra;
		guard = 0;
		while (!sb.is_full && guard < 400) begin
			if ($urandom_range(0, 9) == 0) begin
				random_pop();
			end else begin
				random_push();
			end
			guard++;
		end
		extra = $urandom_range(1, 4);
		repeat (extra) random_push();
	endtask

	// pop mostly until empty, then pop on the empty ring up to twice
	task automatic drain_phase();
		int unsigned guard;
		int unsigned extra;
		guard = 0;
		while (!sb.is_empty && guard < 400) begin
			if ($urandom_range(0, 9) == 0) begin
				random_push();
			end else begin
				random_pop();
			end
			guard++;
		end
		extra = $urandom_range(0, 2);
		repeat (extra) random_pop();
	endtask

	// uniformly mixed requests, all ops and any data
	task automatic mixed_phase(input int unsigned count);
		repeat (count) begin
			issue(op_t'($urandom_range(0, 3)), 8'($urandom));
			n_random++;
			maybe_idle();
		end
	endtask

	initial begin
		int unsigned pick;
		int unsigned guard;

		n_requests = 0;
		n_random = 0;
		quiet_tail = 1'b0;
		idle_pct = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: pop on empty after reset, field extremes, every op
		issue(OP_POP, 8'h00);
		issue(OP_RAW, 8'h00);
		issue(OP_RAW, 8'hff);
		issue(OP_RAW, 8'h5a);
		issue(OP_DIGIT, 8'd0);
		issue(OP_DIGIT, 8'd9);
		issue(OP_DIGIT, 8'd10);
		issue(OP_DIGIT, 8'd15);
		// digit values above 15 run on past 'F' ('G' for 16), and 8'hff wraps to '6'
		issue(OP_DIGIT, 8'd16);
		issue(OP_DIGIT, 8'hff);
		issue(OP_HEX, 8'h00);
		issue(OP_HEX, 8'hff);
		issue(OP_HEX, 8'h9a);
		issue(OP_HEX, 8'ha5);
		guard = 0;
		while (!sb.is_empty && guard < 40) begin
			issue(OP_POP, 8'hff);
			guard++;
		end
		// pop on an empty ring after it drained
		issue(OP_POP, 8'h3c);
		drain_results();

		// random part: well-formed fill and drain runs dominate, with noise mixed in
		while (n_random < 300) begin
			// some phases run with no sender gaps at all
			idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 25);
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				fill_phase();
			end else if (pick < 7) begin
				drain_phase();
			end else begin
				mixed_phase($urandom_range(10, 30));
			end
			if ($urandom_range(0, 4) == 0) begin
				drain_results();
			end
		end

		// last stretch back to back, no gaps
		quiet_tail = 1'b1;
		mixed_phase(40);
		start <= 1'b0;

		guard = 0;
		while (sb.pending() != 0 && guard < 100) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		end

		$display("ran %0d requests: %0d bytes popped, %0d pops on empty,", n_requests,
			sb.n_bytes_out, sb.n_empty_pops);
		$display("ring filled %0d times, %0d pushes hit the full ring, %0d mismatches",
			sb.n_full_hits, sb.n_overflow, sb.errors);
		if (sb.errors == 0) begin
			$display("debug_tx_ring_buffer regression: pass");
		end else begin
			$display("debug_tx_ring_buffer regression: fail");
		end
		$finish;
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#3000000;
		$display("debug_tx_ring_buffer regression: fail");
		$finish;
	end

endmodule
